@@ rtl/cbhd_pkg.sv @@
// shared types, status codes and constants for the cbor head decoder
`default_nettype none

package cbhd_pkg;

  // result status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_INCOMPLETE  = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
  localparam logic [1:0] ST_MALFORMED   = 2'd3;

  // initial byte layout
  localparam int unsigned MAJOR_W  = 3;
  localparam int unsigned INFO_W   = 5;
  localparam int unsigned REMAIN_W = 4;
  localparam int unsigned WCODE_W  = 2;

  localparam logic [INFO_W-1:0]  INLINE_LIMIT  = 5'd24;
  localparam logic [INFO_W-1:0]  EXTENDED_LAST = 5'd27;
  localparam logic [MAJOR_W-1:0] MAJOR_NEG_INT = 3'd1;
  localparam logic [MAJOR_W-1:0] MAJOR_LAST_OK = 3'd5;

  // smallest argument that is legal for 1, 2, 4 and 8 following bytes
  localparam logic [63:0] MIN_ARGUMENT [4] = '{
    64'd24, 64'd256, 64'd65536, 64'd4294967296
  };

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_available;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  major_type;
    logic [63:0] argument;
    logic [3:0]  head_len;
  } out_item_t;

  // decoder state carried between bytes of one head
  typedef struct packed {
    logic [REMAIN_W-1:0] bytes_remaining;
    logic [WCODE_W-1:0]  width_code;
    logic [MAJOR_W-1:0]  held_major;
    logic [63:0]         accumulator;
  } dec_state_t;

endpackage

`default_nettype wire

@@ rtl/cbhd_decode.sv @@
// combinational head decode: one byte against the current state
`default_nettype none

module cbhd_decode (
  input  cbhd_pkg::dec_state_t state,
  input  cbhd_pkg::in_item_t   item,
  output cbhd_pkg::dec_state_t state_next,
  output logic                 res_valid,
  output cbhd_pkg::out_item_t  res
);

  logic [cbhd_pkg::MAJOR_W-1:0]  major;
  logic [cbhd_pkg::INFO_W-1:0]   info;
  logic [cbhd_pkg::WCODE_W-1:0]  wcode_new;
  logic [cbhd_pkg::REMAIN_W-1:0] remain_dec;
  logic [63:0]                   acc_shift;

  assign major      = item.byte_value[7:5];
  assign info       = item.byte_value[4:0];
  assign wcode_new  = cbhd_pkg::WCODE_W'(info - cbhd_pkg::INLINE_LIMIT);
  assign remain_dec = state.bytes_remaining - 4'd1;
  assign acc_shift  = {state.accumulator[55:0], item.byte_value};

  always_comb begin
    state_next = '0;
    res_valid  = 1'b0;
    res        = '0;
    if (state.bytes_remaining == '0) begin
      // initial byte
      priority if (major == cbhd_pkg::MAJOR_NEG_INT || major > cbhd_pkg::MAJOR_LAST_OK) begin
        res_valid  = 1'b1;
        res.status = cbhd_pkg::ST_UNSUPPORTED;
      end else if (info < cbhd_pkg::INLINE_LIMIT) begin
        res_valid      = 1'b1;
        res.status     = cbhd_pkg::ST_OK;
        res.major_type = major;
        res.argument   = 64'(info);
        res.head_len   = 4'd1;
      end else if (info > cbhd_pkg::EXTENDED_LAST) begin
        res_valid  = 1'b1;
        res.status = cbhd_pkg::ST_MALFORMED;
      end else if (item.last_available) begin
        res_valid  = 1'b1;
        res.status = cbhd_pkg::ST_INCOMPLETE;
      end else begin
        state_next.bytes_remaining = 4'd1 << wcode_new;
        state_next.width_code      = wcode_new;
        state_next.held_major      = major;
      end
    end else begin
      // argument byte
      priority if (remain_dec == '0) begin
        res_valid = 1'b1;
        if (acc_shift < cbhd_pkg::MIN_ARGUMENT[state.width_code]) begin
          res.status = cbhd_pkg::ST_MALFORMED;
        end else begin
          res.status     = cbhd_pkg::ST_OK;
          res.major_type = state.held_major;
          res.argument   = acc_shift;
          res.head_len   = (4'd1 << state.width_code) + 4'd1;
        end
      end else if (item.last_available) begin
        res_valid  = 1'b1;
        res.status = cbhd_pkg::ST_INCOMPLETE;
      end else begin
        state_next.bytes_remaining = remain_dec;
        state_next.width_code      = state.width_code;
        state_next.held_major      = state.held_major;
        state_next.accumulator     = acc_shift;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/cbhd_out_reg.sv @@
// result register with valid/stall handshake toward the consumer
`default_nettype none

module cbhd_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  cbhd_pkg::out_item_t load_data,
  output logic                free,
  output logic                out_valid,
  input  logic                out_stall,
  output cbhd_pkg::out_item_t out_data
);

  logic                valid;
  cbhd_pkg::out_item_t data;

  // slot can take a result if empty or being drained this cycle
  assign free      = !valid || !out_stall;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!out_stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/cbor_head_decoder_unit.sv @@
// top level of the cbor data item head decoder
`default_nettype none

// channel | dir | payload               | handshake
// --------+-----+-----------------------+------------------------------
// in      | in  | in_item_t (byte,last) | in_valid / in_stall
// out     | out | out_item_t (result)   | out_valid / out_stall
//
// one byte per cycle unless out_stall holds a result back: a byte goes into the
// input register, then through the decode logic into the result register, so
// a result is registered once more after its byte is accepted; throughput is
// one byte per cycle while no result is held back by out_stall
// reset (rst, synchronous) empties both registers and returns the decoder to
// awaiting an initial byte
// a byte that produces a result waits in the input register only while the
// result register is full and stalled; bytes in the middle of a head pass on
// regardless of out_stall

module cbor_head_decoder_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  cbhd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cbhd_pkg::out_item_t out_data
);

  // input register
  logic               s1_valid;
  logic               s1_valid_next;
  cbhd_pkg::in_item_t s1_data;

  // decoder state across the bytes of one head
  cbhd_pkg::dec_state_t state;
  cbhd_pkg::dec_state_t state_next;

  logic                res_valid;
  cbhd_pkg::out_item_t res;
  logic                out_free;
  logic                advance;
  logic                in_take;

  cbhd_decode u_decode (
    .state      (state),
    .item       (s1_data),
    .state_next (state_next),
    .res_valid  (res_valid),
    .res        (res)
  );

  // byte leaves the input register when its result (if any) has a slot
  assign advance  = s1_valid && (!res_valid || out_free);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_next = in_take || (s1_valid && !advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data <= in_data;
    end
  end

  // state only moves when a byte is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  cbhd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res_valid),
    .load_data (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/cbhd_checker.sv @@
// port-level checker for the head decoder, bound to the top level
`default_nettype none

module cbhd_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input cbhd_pkg::out_item_t out_data,
  input logic                out_valid,
  input logic                out_stall
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // error results carry zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != cbhd_pkg::ST_OK |->
      out_data.major_type == 3'd0 && out_data.argument == 64'd0 &&
      out_data.head_len == 4'd0)
    else $error("error result with nonzero fields");

  // ok results have a legal head length
  a_ok_size: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == cbhd_pkg::ST_OK |->
      out_data.head_len == 4'd1 || out_data.head_len == 4'd2 ||
      out_data.head_len == 4'd3 || out_data.head_len == 4'd5 ||
      out_data.head_len == 4'd9)
    else $error("bad head length");

  // a one-byte head has an inline argument only
  a_inline_arg: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == cbhd_pkg::ST_OK && out_data.head_len == 4'd1 |->
      out_data.argument < 64'd24)
    else $error("inline argument out of range");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output valid after reset");

endmodule

bind cbor_head_decoder_unit cbhd_checker u_cbhd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

`default_nettype wire

@@ dv/testbench.sv @@
// self-checking testbench for the cbor head decoder: directed heads, random streams, backpressure
`timescale 1ns / 100ps

module testbench;

  // generous cycle budget, far above the slowest legal run of ~2000 bytes
  localparam int CYCLE_LIMIT  = 200000;
  // receiver hold-off long enough to fill both pipeline registers
  localparam int LONG_HOLD    = 300;
  // slack after every owed result has been taken, before the verdict
  localparam int DRAIN_CYCLES = 8;
  // random bytes per idling phase
  localparam int PHASE_BYTES  = 420;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  cbhd_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  cbhd_pkg::out_item_t out_data;

  // decoder state as the checker sees it, advanced on every accepted byte
  cbhd_pkg::dec_state_t head_state = '0;
  // decoded heads still owed by the block, oldest first
  cbhd_pkg::out_item_t  pending_heads[$];

  int idle_pct   = 0;   // sender idle chance per cycle, in percent
  int stall_pct  = 0;   // receiver stall chance per cycle, in percent
  int hold_req   = 0;   // bumped to ask the stall process for one long hold-off
  int sent_bytes = 0;
  int errors     = 0;
  int cycles     = 0;

  cbor_head_decoder_unit dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // run-away guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // expected behavior: one byte in, at most one decoded head out
  // ---------------------------------------------------------------------
  function automatic bit decode_byte(input cbhd_pkg::in_item_t item,
                                     output cbhd_pkg::out_item_t res);
    logic [2:0] major;
    logic [4:0] info;
    bit         done;
    res  = '0;
    done = 1'b1;
    if (head_state.bytes_remaining == '0) begin
      // initial byte: major type in the top three bits, additional info below
      major = item.byte_value[7:5];
      info  = item.byte_value[4:0];
      if (major == cbhd_pkg::MAJOR_NEG_INT || major > cbhd_pkg::MAJOR_LAST_OK) begin
        // unsupported major wins over any additional info
        res.status = cbhd_pkg::ST_UNSUPPORTED;
      end else if (info < cbhd_pkg::INLINE_LIMIT) begin
        res.status     = cbhd_pkg::ST_OK;
        res.major_type = major;
        res.argument   = 64'(info);
        res.head_len   = 4'd1;
      end else if (info > cbhd_pkg::EXTENDED_LAST) begin
        // reserved additional info
        res.status = cbhd_pkg::ST_MALFORMED;
      end else begin
        head_state.width_code      = 2'(info - cbhd_pkg::INLINE_LIMIT);
        head_state.bytes_remaining = 4'(1 << head_state.width_code);
        head_state.held_major      = major;
        head_state.accumulator     = '0;
        if (item.last_available) res.status = cbhd_pkg::ST_INCOMPLETE;
        else done = 1'b0;
      end
    end else begin
      // argument byte, most significant first
      head_state.accumulator     = {head_state.accumulator[55:0], item.byte_value};
      head_state.bytes_remaining = head_state.bytes_remaining - 4'd1;
      if (head_state.bytes_remaining == '0) begin
        if (head_state.accumulator < cbhd_pkg::MIN_ARGUMENT[head_state.width_code]) begin
          // argument would have fit a shorter encoding
          res.status = cbhd_pkg::ST_MALFORMED;
        end else begin
          res.status     = cbhd_pkg::ST_OK;
          res.major_type = head_state.held_major;
          res.argument   = head_state.accumulator;
          res.head_len   = 4'((1 << head_state.width_code) + 1);
        end
      end else if (item.last_available) begin
        // stream ran dry in the middle of the argument
        res.status = cbhd_pkg::ST_INCOMPLETE;
      end else begin
        done = 1'b0;
      end
    end
    // every result sends the decoder back to awaiting an initial byte
    if (done) head_state = '0;
    return done;
  endfunction

  // ---------------------------------------------------------------------
  // sender: one transaction per call, prediction made at acceptance
  // ---------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] value, input logic last);
    cbhd_pkg::in_item_t  item;
    cbhd_pkg::out_item_t res;
    // random gap before the transaction; valid stays low during it
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    item.byte_value     = value;
    item.last_available = last;
    in_valid <= 1'b1;
    in_data  <= item;
    // accepted at the first edge where stall is low; payload held meanwhile
    do @(posedge clk); while (in_stall);
    if (decode_byte(item, res)) pending_heads.push_back(res);
    sent_bytes++;
  endtask

  // one head: initial byte, then up to cut argument bytes; a cut short of the
  // full width puts last_available on the final byte sent
  task automatic send_head(input logic [2:0] major, input logic [4:0] info,
                           input logic [63:0] arg, input int cut, input logic last_end);
    int   n;
    int   k;
    logic fin_last;
    n = (info >= cbhd_pkg::INLINE_LIMIT && info <= cbhd_pkg::EXTENDED_LAST) ?
        (1 << (info - cbhd_pkg::INLINE_LIMIT)) : 0;
    k = (cut < n) ? cut : n;
    fin_last = (cut < n) ? 1'b1 : last_end;
    send_byte({major, info}, (k == 0) ? fin_last : 1'b0);
    for (int i = 0; i < k; i++)
      send_byte(arg[8*(n-1-i) +: 8], (i == k - 1) ? fin_last : 1'b0);
  endtask

  // mostly well-formed heads with random content, plus stray bytes,
  // unsupported majors, reserved info, non-minimal and truncated arguments
  task automatic send_random_head();
    logic [2:0]  major;
    logic [4:0]  info;
    logic [63:0] arg;
    logic [63:0] floor_arg;
    logic [63:0] mask;
    int          n;
    int          pick;
    int          cut;
    pick = $urandom_range(99);
    if (pick < 10) begin
      send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      return;
    end
    if (pick < 15) begin
      case ($urandom_range(2))
        0:       major = 3'd1;
        1:       major = 3'd6;
        default: major = 3'd7;
      endcase
    end else begin
      case ($urandom_range(4))
        0:       major = 3'd0;
        1:       major = 3'd2;
        2:       major = 3'd3;
        3:       major = 3'd4;
        default: major = 3'd5;
      endcase
    end
    pick = $urandom_range(9);
    if (pick < 4)      info = 5'($urandom_range(23));
    else if (pick < 9) info = 5'($urandom_range(27, 24));
    else               info = 5'($urandom_range(31, 28));
    n   = (info >= cbhd_pkg::INLINE_LIMIT && info <= cbhd_pkg::EXTENDED_LAST) ?
          (1 << (info - cbhd_pkg::INLINE_LIMIT)) : 0;
    arg = '0;
    if (n > 0) begin
      floor_arg = cbhd_pkg::MIN_ARGUMENT[2'(info - cbhd_pkg::INLINE_LIMIT)];
      mask      = {64{1'b1}} >> (64 - 8 * n);
      arg       = {32'($urandom), 32'($urandom)} & mask;
      case ($urandom_range(9))
        0:       arg = floor_arg - 64'd1;  // one below the shortest legal value
        1:       arg = floor_arg;
        2:       arg = mask;
        3:       arg = arg % floor_arg;    // non-minimal encoding
        default: if (arg < floor_arg) arg = arg | floor_arg;
      endcase
    end
    cut = ($urandom_range(9) == 0) ? $urandom_range(n) : n;
    send_head(major, info, arg, cut, 1'($urandom_range(1)));
  endtask

  task automatic run_random_bytes(input int count);
    int target;
    target = sent_bytes + count;
    while (sent_bytes < target) send_random_head();
  endtask

  // ---------------------------------------------------------------------
  // receiver: random stall, or one long hold-off when asked
  // ---------------------------------------------------------------------
  initial begin : drive_out_stall
    int hold_done;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_done) begin
        hold_done++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // result checker: each accepted transaction against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    cbhd_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_heads.size() == 0) begin
        $error("unexpected result: status %0d major_type %0d argument %0h head_len %0d",
               out_data.status, out_data.major_type, out_data.argument,
               out_data.head_len);
        errors++;
      end else begin
        want = pending_heads.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          errors++;
        end
        if (out_data.major_type !== want.major_type) begin
          $error("major_type: expected %0d, got %0d", want.major_type, out_data.major_type);
          errors++;
        end
        if (out_data.argument !== want.argument) begin
          $error("argument: expected %0h, got %0h", want.argument, out_data.argument);
          errors++;
        end
        if (out_data.head_len !== want.head_len) begin
          $error("head_len: expected %0d, got %0d", want.head_len, out_data.head_len);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // single-byte heads: inline extremes, unsupported majors, reserved info
  task automatic test_inline_and_errors();
    send_head(3'd0, 5'd0,  '0, 0, 1'b0);   // smallest inline head
    send_head(3'd5, 5'd23, '0, 0, 1'b1);   // largest inline, end of stream
    send_head(3'd1, 5'd31, '0, 0, 1'b0);   // unsupported major before reserved info
    send_head(3'd6, 5'd24, '0, 0, 1'b0);   // unsupported major, stream ends too
    send_head(3'd7, 5'd0,  '0, 0, 1'b0);
    send_head(3'd4, 5'd28, '0, 0, 1'b0);   // reserved additional info
  endtask

  // every argument width, at and around the minimal-encoding bounds
  task automatic test_extended_arguments();
    send_head(3'd0, 5'd24, 64'd23, 1, 1'b0);             // non-minimal, one byte
    send_head(3'd2, 5'd25, 64'd256, 2, 1'b1);            // minimal, two bytes
    send_head(3'd3, 5'd26, 64'h0000_FFFF, 4, 1'b0);      // non-minimal, four bytes
    send_head(3'd0, 5'd27, {64{1'b1}}, 8, 1'b0);         // largest argument
  endtask

  // stream ending on the initial byte and in the middle of an argument
  task automatic test_truncated_heads();
    send_head(3'd4, 5'd24, '0, 0, 1'b0);
    send_head(3'd5, 5'd25, 64'h0100, 1, 1'b0);
  endtask

  task automatic test_random_no_idling();
    idle_pct  = 0;
    stall_pct <= 0;
    run_random_bytes(PHASE_BYTES);
  endtask

  task automatic test_random_sender_idle();
    idle_pct  = 67;
    stall_pct <= 0;
    run_random_bytes(PHASE_BYTES);
  endtask

  task automatic test_random_receiver_stall();
    idle_pct  = 0;
    stall_pct <= 67;
    run_random_bytes(PHASE_BYTES);
  endtask

  task automatic test_random_both_idle();
    idle_pct  = 33;
    stall_pct <= 33;
    run_random_bytes(PHASE_BYTES);
  endtask

  // receiver holds off while bytes keep coming, so the block fills and stalls
  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct <= 0;
    hold_req  <= hold_req + 1;
    run_random_bytes(150);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_inline_and_errors();
    test_extended_arguments();
    test_truncated_heads();
    test_random_no_idling();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_backpressure();

    // drain: stop offering, let the receiver take everything still owed
    in_valid  <= 1'b0;
    stall_pct <= 0;
    while (pending_heads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
